// ===== design/sll_pkg.sv =====
// Shared types and constants for the cursor-array linked list.
// Used by sll_ctrl, sll_datapath and static_linked_list; depends on nothing.
package sll_pkg;

  localparam int MAX_ENTRIES = 64;
  localparam int DATA_WIDTH  = 32;

  localparam int LINK_W  = 7;
  localparam int POS_W   = 6;
  localparam int IN_W    = 32;
  localparam int STORE_W = (DATA_WIDTH < IN_W) ? DATA_WIDTH : IN_W;
  localparam int LINK_AW = $clog2(MAX_ENTRIES + 1);

  localparam logic [LINK_W-1:0] FREE_MARK = '1;
  localparam logic [LINK_W-1:0] MAX_IDX   = LINK_W'(MAX_ENTRIES);

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_GET    = 2'd1,
    ACT_DELETE = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_SEARCH,
    S_WALK,
    S_INS_LINK,
    S_INS_HEAD,
    S_FETCH,
    S_DEL_FREE
  } state_t;

  typedef enum logic [1:0] {
    RA_HEAD,
    RA_ONE,
    RA_NEXT,
    RA_IDX_INC
  } rd_sel_t;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_SLOT,
    WR_CUR_SLOT,
    WR_CUR_NX,
    WR_FREE_OBJ
  } wr_sel_t;

  typedef struct packed {
    logic    ld_req;
    logic    clear_all;
    rd_sel_t rd_sel;
    logic    idx_init;
    logic    idx_inc;
    logic    walk_init;
    logic    walk_step;
    logic    slot_ld;
    logic    nxt_ld;
    wr_sel_t wr_sel;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    data_ld;
    logic    fin;
    logic    fin_ok;
  } ctl_cmd_t;

  typedef struct packed {
    action_t action;
    logic    ins_ok;
    logic    pos_lt_count;
    logic    link_free;
    logic    idx_at_cap;
    logic    walk_more;
    logic    nx_zero;
  } ctl_stat_t;

endpackage

// ===== design/static_linked_list.sv =====
// Top level of the cursor-array linked list.
// Depends on sll_pkg, sll_ctrl and sll_datapath.
//
// Usage:
//   Command channel: a beat (action, position, insert_data) is taken at a
//   rising edge with start high and busy low. Actions: insert, get, delete,
//   clear. One result beat (ok, data_out, length) follows each command,
//   flagged by done for exactly one cycle; the receiver cannot stall it.
//   Configuration: cfg_we writes cfg_wdata into capacity; the user must
//   write it only while idle, as the block itself does not enforce it.
//   Sequence: clear and rejected actions finish at dispatch; get and delete
//   walk from the head to the position, then fetch (delete then unlinks and
//   frees the node); insert searches slots 1..capacity for a free one, then
//   walks from the head, then does two link writes.
//   Throughput: one command at a time; busy drops in the cycle done rises,
//   so the next command may be taken while the result is shown.
//   Reset: empty list, all slots free, capacity at its maximum; no clearing
//   pass is needed.
module static_linked_list (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 action,
  input  logic [sll_pkg::POS_W-1:0]  position,
  input  logic [sll_pkg::IN_W-1:0]   insert_data,
  input  logic                       cfg_we,
  input  logic [sll_pkg::LINK_W-1:0] cfg_wdata,
  output logic                       done,
  output logic                       ok,
  output logic [sll_pkg::IN_W-1:0]   data_out,
  output logic [sll_pkg::LINK_W-1:0] length
);

  sll_pkg::ctl_cmd_t  cmd;
  sll_pkg::ctl_stat_t stat;

  sll_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  sll_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .action      (action),
    .position    (position),
    .insert_data (insert_data),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .cmd         (cmd),
    .stat        (stat),
    .done        (done),
    .ok          (ok),
    .data_out    (data_out),
    .length      (length)
  );

endmodule

// ===== design/sll_ctrl.sv =====
// Sequencer for the linked list: dispatch, free-slot search, link walk, updates.
// Depends on sll_pkg; drives sll_datapath through ctl_cmd_t.
module sll_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  sll_pkg::ctl_stat_t stat,
  output sll_pkg::ctl_cmd_t  cmd,
  output logic               busy
);

  sll_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sll_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      sll_pkg::S_IDLE: begin
        if (start) state_next = sll_pkg::S_DISPATCH;
      end
      sll_pkg::S_DISPATCH: begin
        unique case (stat.action) inside
          sll_pkg::ACT_INSERT:
            state_next = stat.ins_ok ? sll_pkg::S_SEARCH : sll_pkg::S_IDLE;
          sll_pkg::ACT_GET, sll_pkg::ACT_DELETE:
            state_next = stat.pos_lt_count ? sll_pkg::S_WALK : sll_pkg::S_IDLE;
          default: state_next = sll_pkg::S_IDLE;
        endcase
      end
      sll_pkg::S_SEARCH: begin
        if (stat.link_free) state_next = sll_pkg::S_WALK;
        else if (stat.idx_at_cap) state_next = sll_pkg::S_IDLE;
      end
      sll_pkg::S_WALK: begin
        if (stat.action == sll_pkg::ACT_INSERT) begin
          if (!(stat.walk_more && !stat.nx_zero)) state_next = sll_pkg::S_INS_LINK;
        end else if (!stat.walk_more) begin
          state_next = stat.nx_zero ? sll_pkg::S_IDLE : sll_pkg::S_FETCH;
        end
      end
      sll_pkg::S_INS_LINK: state_next = sll_pkg::S_INS_HEAD;
      sll_pkg::S_INS_HEAD: state_next = sll_pkg::S_IDLE;
      sll_pkg::S_FETCH: begin
        state_next = (stat.action == sll_pkg::ACT_DELETE) ? sll_pkg::S_DEL_FREE
                                                         : sll_pkg::S_IDLE;
      end
      sll_pkg::S_DEL_FREE: state_next = sll_pkg::S_IDLE;
      default: state_next = sll_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state)
      sll_pkg::S_IDLE: begin
        cmd.ld_req = start;
      end
      sll_pkg::S_DISPATCH: begin
        unique case (stat.action) inside
          sll_pkg::ACT_INSERT: begin
            if (stat.ins_ok) begin
              cmd.idx_init = 1'b1;
              cmd.rd_sel   = sll_pkg::RA_ONE;
            end else begin
              cmd.fin = 1'b1;
            end
          end
          sll_pkg::ACT_GET, sll_pkg::ACT_DELETE: begin
            if (stat.pos_lt_count) begin
              cmd.walk_init = 1'b1;
              cmd.rd_sel    = sll_pkg::RA_HEAD;
            end else begin
              cmd.fin = 1'b1;
            end
          end
          default: begin
            cmd.clear_all = 1'b1;
            cmd.fin       = 1'b1;
            cmd.fin_ok    = 1'b1;
          end
        endcase
      end
      sll_pkg::S_SEARCH: begin
        if (stat.link_free) begin
          cmd.slot_ld   = 1'b1;
          cmd.walk_init = 1'b1;
          cmd.rd_sel    = sll_pkg::RA_HEAD;
        end else if (stat.idx_at_cap) begin
          cmd.fin = 1'b1;
        end else begin
          cmd.idx_inc = 1'b1;
          cmd.rd_sel  = sll_pkg::RA_IDX_INC;
        end
      end
      sll_pkg::S_WALK: begin
        if (stat.action == sll_pkg::ACT_INSERT) begin
          // appends once the list ends before the position is reached
          if (stat.walk_more && !stat.nx_zero) begin
            cmd.walk_step = 1'b1;
            cmd.rd_sel    = sll_pkg::RA_NEXT;
          end else begin
            cmd.nxt_ld = 1'b1;
          end
        end else if (stat.walk_more) begin
          cmd.walk_step = 1'b1;
          cmd.rd_sel    = sll_pkg::RA_NEXT;
        end else if (stat.nx_zero) begin
          cmd.fin = 1'b1;
        end else begin
          cmd.nxt_ld = 1'b1;
          cmd.rd_sel = sll_pkg::RA_NEXT;
        end
      end
      sll_pkg::S_INS_LINK: begin
        cmd.wr_sel = sll_pkg::WR_SLOT;
      end
      sll_pkg::S_INS_HEAD: begin
        cmd.wr_sel  = sll_pkg::WR_CUR_SLOT;
        cmd.cnt_inc = 1'b1;
        cmd.fin     = 1'b1;
        cmd.fin_ok  = 1'b1;
      end
      sll_pkg::S_FETCH: begin
        cmd.data_ld = 1'b1;
        if (stat.action == sll_pkg::ACT_DELETE) begin
          cmd.wr_sel = sll_pkg::WR_CUR_NX;
        end else begin
          cmd.fin    = 1'b1;
          cmd.fin_ok = 1'b1;
        end
      end
      sll_pkg::S_DEL_FREE: begin
        cmd.wr_sel  = sll_pkg::WR_FREE_OBJ;
        cmd.cnt_dec = 1'b1;
        cmd.fin     = 1'b1;
        cmd.fin_ok  = 1'b1;
      end
      default: cmd = '0;
    endcase
  end

  assign busy = (state != sll_pkg::S_IDLE);

  a_accept_dispatch: assert property (@(posedge clk) disable iff (rst)
    (state == sll_pkg::S_IDLE && start) |=> state == sll_pkg::S_DISPATCH)
    else $error("accepted beat did not reach dispatch");

  a_fin_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.fin |=> state == sll_pkg::S_IDLE)
    else $error("result issued while sequencer stays busy");

endmodule

// ===== design/sll_datapath.sv =====
// Node store, cursors, counters and result registers of the linked list.
// Depends on sll_pkg; controlled by sll_ctrl through ctl_cmd_t / ctl_stat_t.
module sll_datapath (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [1:0]                 action,
  input  logic [sll_pkg::POS_W-1:0]  position,
  input  logic [sll_pkg::IN_W-1:0]   insert_data,
  input  logic                       cfg_we,
  input  logic [sll_pkg::LINK_W-1:0] cfg_wdata,
  input  sll_pkg::ctl_cmd_t          cmd,
  output sll_pkg::ctl_stat_t         stat,
  output logic                       done,
  output logic                       ok,
  output logic [sll_pkg::IN_W-1:0]   data_out,
  output logic [sll_pkg::LINK_W-1:0] length
);

  localparam int LW = sll_pkg::LINK_W;
  localparam int AW = sll_pkg::LINK_AW;
  localparam int SW = sll_pkg::STORE_W;

  // node store: data has no reset, link slots read their reset value until valid
  logic [LW-1:0] link_mem [0:sll_pkg::MAX_ENTRIES];
  logic [SW-1:0] data_mem [0:sll_pkg::MAX_ENTRIES];
  logic          link_valid [0:sll_pkg::MAX_ENTRIES];

  sll_pkg::action_t      req_action;
  logic [sll_pkg::POS_W-1:0] req_pos;
  logic [SW-1:0]         req_word;
  logic [LW-1:0]         capacity;
  logic [LW-1:0]         count, count_next;
  logic [LW-1:0]         idx;
  logic [LW-1:0]         cur;
  logic [LW-1:0]         walk_i;
  logic [LW-1:0]         slot;
  logic [LW-1:0]         nxt;

  logic [AW-1:0]         rd_addr, addr_q;
  logic [LW-1:0]         link_q;
  logic [SW-1:0]         data_q;
  logic                  valid_q;
  logic [LW-1:0]         link_raw, nx, cap, idx_plus;

  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [LW-1:0]         wr_val;

  assign cap      = (capacity > sll_pkg::MAX_IDX) ? sll_pkg::MAX_IDX : capacity;
  assign idx_plus = idx + LW'(1);

  assign link_raw = valid_q ? link_q :
                    ((addr_q == '0) ? '0 : sll_pkg::FREE_MARK);
  // out-of-range links and the free mark end the list
  assign nx = (link_raw == '0 || link_raw > sll_pkg::MAX_IDX) ? '0 : link_raw;

  always_comb begin
    case (cmd.rd_sel)
      sll_pkg::RA_HEAD:    rd_addr = '0;
      sll_pkg::RA_ONE:     rd_addr = AW'(1);
      sll_pkg::RA_NEXT:    rd_addr = nx[AW-1:0];
      sll_pkg::RA_IDX_INC: rd_addr = idx_plus[AW-1:0];
      default:             rd_addr = '0;
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = slot[AW-1:0];
    wr_val  = nxt;
    case (cmd.wr_sel)
      sll_pkg::WR_SLOT: begin
        wr_en = 1'b1;
      end
      sll_pkg::WR_CUR_SLOT: begin
        wr_en   = 1'b1;
        wr_addr = cur[AW-1:0];
        wr_val  = slot;
      end
      sll_pkg::WR_CUR_NX: begin
        wr_en   = 1'b1;
        wr_addr = cur[AW-1:0];
        wr_val  = nx;
      end
      default: wr_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    link_q  <= link_mem[rd_addr];
    data_q  <= data_mem[rd_addr];
    valid_q <= link_valid[rd_addr];
    addr_q  <= rd_addr;
    if (wr_en) link_mem[wr_addr] <= wr_val;
    if (cmd.wr_sel == sll_pkg::WR_SLOT) data_mem[slot[AW-1:0]] <= req_word;
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear_all) begin
      for (int k = 0; k <= sll_pkg::MAX_ENTRIES; k++) link_valid[k] <= 1'b0;
    end else if (wr_en) begin
      link_valid[wr_addr] <= 1'b1;
    end else if (cmd.wr_sel == sll_pkg::WR_FREE_OBJ) begin
      link_valid[nxt[AW-1:0]] <= 1'b0;
    end
  end

  always_comb begin
    count_next = count;
    if (cmd.clear_all) count_next = '0;
    else if (cmd.cnt_inc) count_next = count + LW'(1);
    else if (cmd.cnt_dec) count_next = count - LW'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= sll_pkg::MAX_IDX;
      count    <= '0;
      done     <= 1'b0;
    end else begin
      if (cfg_we) capacity <= cfg_wdata;
      count <= count_next;
      done  <= cmd.fin;
    end
  end

  // request, cursors and result payload
  always_ff @(posedge clk) begin
    if (cmd.ld_req) begin
      req_action <= sll_pkg::action_t'(action);
      req_pos    <= position;
      req_word   <= insert_data[SW-1:0];
      data_out   <= '0;
    end
    if (cmd.idx_init) idx <= LW'(1);
    else if (cmd.idx_inc) idx <= idx_plus;
    if (cmd.walk_init) begin
      cur    <= '0;
      walk_i <= '0;
    end else if (cmd.walk_step) begin
      cur    <= nx;
      walk_i <= walk_i + LW'(1);
    end
    if (cmd.slot_ld) slot <= idx;
    if (cmd.nxt_ld) nxt <= nx;
    if (cmd.data_ld) data_out <= sll_pkg::IN_W'(data_q);
    if (cmd.fin) begin
      ok     <= cmd.fin_ok;
      length <= count_next;
    end
  end

  always_comb begin
    stat.action       = req_action;
    stat.ins_ok       = ({1'b0, count} + (LW + 1)'(1) <= {1'b0, cap}) &&
                        ({1'b0, req_pos} < cap);
    stat.pos_lt_count = ({1'b0, req_pos} < count);
    stat.link_free    = (link_raw == sll_pkg::FREE_MARK);
    stat.idx_at_cap   = (idx == cap);
    stat.walk_more    = (walk_i < {1'b0, req_pos}) && (walk_i < sll_pkg::MAX_IDX);
    stat.nx_zero      = (nx == '0);
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= sll_pkg::MAX_IDX)
    else $error("element count beyond store size");

  a_clear_empty: assert property (@(posedge clk) disable iff (rst)
    cmd.clear_all |=> (count == '0 && length == '0 && ok))
    else $error("clear did not empty the list");

  a_done_follows_fin: assert property (@(posedge clk) disable iff (rst)
    cmd.fin |=> done)
    else $error("result strobe missing after finish");

endmodule
